### design/skt_pkg.sv
`timescale 1ns / 1ps

package skt_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int CMD_W             = 2;
   localparam int ROLE_W            = 4;
   localparam int USER_W            = 16;
   localparam int REQ_TDATA_W       = 24;
   localparam int RSP_TDATA_W       = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_QUERY  = 2'd0,
      CMD_LOGIN  = 2'd1,
      CMD_LOGOUT = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ROLE_W-1:0] role;
      logic [USER_W-1:0] user;
   } req_type;

   typedef struct packed {
      logic              live;
      logic [ROLE_W-1:0] role;
      logic [USER_W-1:0] user;
   } entry_type;

endpackage

### design/session_key_table.sv
`timescale 1ns / 1ps

// Session table keyed by (role, user id). Each request transaction carries a
// command (query, login, logout) and a key and returns one transaction with the
// ok flag. The key/live table sits in one single-port-read synchronous memory
// that is scanned one entry per cycle over the used slots (no slots while the
// table is still empty; used_count grows by one per appending login, up to
// TABLE_ENTRIES); the decision then waits until the result register is free
// (no pending result, or rsp_tready). One request is in work at a time; the
// result register lets the next request be accepted while the previous result
// is still pending. No clearing pass after reset: the used count alone marks
// which slots are valid.
// req_tdata: command [1:0], role [5:2], user_id [21:6], zero [23:22].
// rsp_tdata: ok [0], zero [7:1].

module session_key_table #(
   parameter int TABLE_ENTRIES = skt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [skt_pkg::REQ_TDATA_W-1:0] req_tdata,  // command, role, user_id
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [skt_pkg::RSP_TDATA_W-1:0] rsp_tdata   // ok
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   skt_pkg::req_type   req_item;
   skt_pkg::entry_type wr_data;
   skt_pkg::entry_type rd_data;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic               done;
   logic               ok;
   logic               out_free;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;

   assign req_item.cmd  = req_tdata[1:0];
   assign req_item.role = req_tdata[5:2];
   assign req_item.user = req_tdata[21:6];

   assign out_free = !rsp_valid_ff || rsp_tready;

   skt_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .AW            (AW),
      .CW            (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_item    (req_item),
      .out_free    (out_free),
      .done        (done),
      .ok          (ok),
      .mem_wr_en   (wr_en),
      .mem_wr_addr (wr_addr),
      .mem_wr_data (wr_data),
      .mem_rd_addr (rd_addr),
      .mem_rd_data (rd_data)
   );

   skt_mem #(
      .DEPTH (TABLE_ENTRIES),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(skt_pkg::RSP_TDATA_W-1){1'b0}}, rsp_ok_ff};

endmodule

### design/skt_mem.sv
`timescale 1ns / 1ps

module skt_mem #(
   parameter int DEPTH = skt_pkg::TABLE_ENTRIES_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  skt_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output skt_pkg::entry_type  rd_data
);

   skt_pkg::entry_type mem [DEPTH];
   skt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/skt_ctrl.sv
`timescale 1ns / 1ps

module skt_ctrl #(
   parameter int TABLE_ENTRIES = skt_pkg::TABLE_ENTRIES_DEF,
   parameter int AW            = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
   parameter int CW            = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  skt_pkg::req_type    req_item,
   input  logic                out_free,
   output logic                done,
   output logic                ok,
   output logic                mem_wr_en,
   output logic [AW-1:0]       mem_wr_addr,
   output skt_pkg::entry_type  mem_wr_data,
   output logic [AW-1:0]       mem_rd_addr,
   input  skt_pkg::entry_type  mem_rd_data
);

   localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

   skt_pkg::state_type state_ff, state_in;
   skt_pkg::cmd_type   cmd_ff, cmd_in;
   logic [skt_pkg::ROLE_W-1:0] role_ff, role_in;
   logic [skt_pkg::USER_W-1:0] user_ff, user_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          rd_valid_ff, rd_valid_in;
   logic          live_hit_ff, live_hit_in;
   logic          free_found_ff, free_found_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic          key_found_ff, key_found_in;
   logic [AW-1:0] key_idx_ff, key_idx_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;

   logic accept;
   logic issue;
   logic key_match;
   logic scan_end;
   logic can_append;

   assign accept     = req_valid && req_ready;
   assign issue      = (state_ff == skt_pkg::ST_SCAN) && (issue_ff < used_ff);
   assign scan_end   = (state_ff == skt_pkg::ST_SCAN) && !issue && !rd_valid_ff;
   assign key_match  = (mem_rd_data.role == role_ff) && (mem_rd_data.user == user_ff);
   assign can_append = used_ff < FULL;
   assign mem_rd_addr = issue_ff[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         skt_pkg::ST_IDLE: begin
            if (accept) state_in = skt_pkg::ST_SCAN;
         end
         skt_pkg::ST_SCAN: begin
            if (scan_end) state_in = skt_pkg::ST_DECIDE;
         end
         skt_pkg::ST_DECIDE: begin
            if (out_free) state_in = skt_pkg::ST_IDLE;
         end
         default: state_in = skt_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready        = 1'b0;
      done             = 1'b0;
      ok               = 1'b0;
      mem_wr_en        = 1'b0;
      mem_wr_addr      = free_idx_ff;
      mem_wr_data.live = 1'b1;
      mem_wr_data.role = role_ff;
      mem_wr_data.user = user_ff;
      used_in          = used_ff;
      unique case (state_ff)
         skt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         skt_pkg::ST_SCAN: begin
         end
         skt_pkg::ST_DECIDE: begin
            done = out_free;
            case (cmd_ff)
               skt_pkg::CMD_QUERY: begin
                  ok = live_hit_ff;
               end
               skt_pkg::CMD_LOGIN: begin
                  if (!live_hit_ff && free_found_ff) begin
                     ok        = 1'b1;
                     mem_wr_en = out_free;
                  end else if (!live_hit_ff && can_append) begin
                     ok          = 1'b1;
                     mem_wr_en   = out_free;
                     mem_wr_addr = used_ff[AW-1:0];
                     if (out_free) used_in = used_ff + CW'(1);
                  end
               end
               skt_pkg::CMD_LOGOUT: begin
                  mem_wr_en        = out_free && key_found_ff;
                  mem_wr_addr      = key_idx_ff;
                  mem_wr_data.live = 1'b0;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // scan datapath
   always_comb begin
      cmd_in        = cmd_ff;
      role_in       = role_ff;
      user_in       = user_ff;
      issue_in      = issue_ff;
      rd_valid_in   = issue;
      rd_idx_in     = issue_ff[AW-1:0];
      live_hit_in   = live_hit_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      key_found_in  = key_found_ff;
      key_idx_in    = key_idx_ff;
      if (accept) begin
         cmd_in        = skt_pkg::cmd_type'(req_item.cmd);
         role_in       = req_item.role;
         user_in       = req_item.user;
         issue_in      = '0;
         live_hit_in   = 1'b0;
         free_found_in = 1'b0;
         key_found_in  = 1'b0;
      end else begin
         if (issue) issue_in = issue_ff + CW'(1);
         if (rd_valid_ff) begin
            if (mem_rd_data.live && key_match) live_hit_in = 1'b1;
            if (!mem_rd_data.live && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = rd_idx_ff;
            end
            if (key_match && !key_found_ff) begin
               key_found_in = 1'b1;
               key_idx_in   = rd_idx_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= skt_pkg::ST_IDLE;
         used_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         rd_valid_ff <= rd_valid_in;
      end
      cmd_ff        <= cmd_in;
      role_ff       <= role_in;
      user_ff       <= user_in;
      issue_ff      <= issue_in;
      rd_idx_ff     <= rd_idx_in;
      live_hit_ff   <= live_hit_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      key_found_ff  <= key_found_in;
      key_idx_ff    <= key_idx_in;
   end

endmodule
